[rtl/mh2_pkg.sv]
// mh2_pkg: shared types and constants for the murmurhash2 32-bit block
`default_nettype none

package mh2_pkg;

  // mixing constants and seed reset value
  localparam logic [31:0] MixMul     = 32'h5bd1_e995;
  localparam int unsigned MixShift   = 24;
  localparam int unsigned FinShiftA  = 13;
  localparam int unsigned FinShiftB  = 15;
  localparam logic [31:0] SeedReset  = 32'hEE6B_27EB;

  // register indexes on the configuration port
  localparam logic RegSeed = 1'b0;

  // operand select for the shared multiplier
  typedef enum logic [1:0] {
    OPA_WORD   = 2'd0,
    OPA_KSHIFT = 2'd1,
    OPA_HMIX   = 2'd2,
    OPA_HFIN   = 2'd3
  } mh2_opa_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     load;
    logic     tail;
    mh2_opa_e opa;
    logic     k_we;
    logic     h_we;
    logic     h_xor_k;
    logic     fin_we;
  } mh2_cmd_t;

endpackage

`default_nettype wire

[rtl/mh2_dp.sv]
// mh2_dp: hash datapath with one shared 32x32 multiplier
`default_nettype none

module mh2_dp
  import mh2_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire mh2_cmd_t    cmd_i,
  input  wire logic [31:0] seed_i,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic [31:0] total_length_i,
  input  wire logic        first_item_i,
  output logic      [31:0] hash_value_o
);

  logic [31:0] h_q, h_d;
  logic [31:0] k_q;
  logic [31:0] hash_q;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic [31:0] base;
  logic [31:0] tail_mask;
  logic [31:0] fin_val;

  // multiplier operand select
  always_comb begin
    case (cmd_i.opa)
      OPA_WORD:   mul_a = data_word_i;
      OPA_KSHIFT: mul_a = k_q ^ (k_q >> MixShift);
      OPA_HMIX:   mul_a = h_q;
      OPA_HFIN:   mul_a = h_q ^ (h_q >> FinShiftA);
      default:    mul_a = h_q;
    endcase
  end

  assign prod = mul_a * MixMul;

  // tail byte mask
  always_comb begin
    case (byte_count_i[1:0])
      2'd1:    tail_mask = 32'h0000_00FF;
      2'd2:    tail_mask = 32'h0000_FFFF;
      2'd3:    tail_mask = 32'h00FF_FFFF;
      default: tail_mask = 32'h0000_0000;
    endcase
  end

  // start value of the accumulator for an item
  assign base    = first_item_i ? (seed_i ^ total_length_i) : h_q;
  assign fin_val = h_q ^ (h_q >> FinShiftB);

  // accumulator next value
  always_comb begin
    h_d = h_q;
    if (cmd_i.load) begin
      h_d = cmd_i.tail ? (base ^ (data_word_i & tail_mask)) : base;
    end else if (cmd_i.h_we) begin
      h_d = cmd_i.h_xor_k ? (prod ^ k_q) : prod;
    end else if (cmd_i.fin_we) begin
      h_d = fin_val;
    end
  end

  // accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= '0;
    end else begin
      h_q <= h_d;
    end
  end

  // word product and output holding register
  always_ff @(posedge clk_i) begin
    if (cmd_i.k_we) begin
      k_q <= prod;
    end
    if (cmd_i.fin_we) begin
      hash_q <= fin_val;
    end
  end

  assign hash_value_o = hash_q;

endmodule

`default_nettype wire

[rtl/mh2_ctrl.sv]
// mh2_ctrl: sequencing state machine and item handshakes
`default_nettype none

module mh2_ctrl
  import mh2_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       data_valid_i,
  output logic            data_ready_o,
  input  wire logic [2:0] byte_count_i,
  input  wire logic       last_item_i,
  output logic            hash_valid_o,
  input  wire logic       hash_ready_i,
  output mh2_cmd_t        cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_MIX_K2  = 6'b000010,
    S_MIX_H   = 6'b000100,
    S_TAIL    = 6'b001000,
    S_FIN_MUL = 6'b010000,
    S_FIN_OUT = 6'b100000
  } mh2_state_e;

  mh2_state_e state_q, state_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       full_word;
  logic       tail_bytes;
  logic       out_free;

  // input side is open only while idle
  assign data_ready_o = (state_q == S_IDLE);

  assign accept     = data_valid_i && data_ready_o;
  assign full_word  = !last_item_i || byte_count_i[2];
  assign tail_bytes = last_item_i && !byte_count_i[2] && (byte_count_i[1:0] != 2'd0);
  assign out_free   = !out_valid_q || hash_ready_i;

  // next state and datapath commands
  always_comb begin
    state_d       = state_q;
    last_d        = last_q;
    cmd_o         = '0;
    cmd_o.opa     = OPA_WORD;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load   = accept;
        cmd_o.tail   = tail_bytes;
        cmd_o.k_we   = accept;
        if (accept) begin
          last_d = last_item_i;
          if (full_word) begin
            state_d = S_MIX_K2;
          end else if (tail_bytes) begin
            state_d = S_TAIL;
          end else begin
            state_d = S_FIN_MUL;
          end
        end
      end
      S_MIX_K2: begin
        cmd_o.opa  = OPA_KSHIFT;
        cmd_o.k_we = 1'b1;
        state_d    = S_MIX_H;
      end
      S_MIX_H: begin
        cmd_o.opa     = OPA_HMIX;
        cmd_o.h_we    = 1'b1;
        cmd_o.h_xor_k = 1'b1;
        state_d       = last_q ? S_FIN_MUL : S_IDLE;
      end
      S_TAIL: begin
        cmd_o.opa  = OPA_HMIX;
        cmd_o.h_we = 1'b1;
        state_d    = S_FIN_MUL;
      end
      S_FIN_MUL: begin
        cmd_o.opa  = OPA_HFIN;
        cmd_o.h_we = 1'b1;
        state_d    = S_FIN_OUT;
      end
      S_FIN_OUT: begin
        cmd_o.opa    = OPA_HFIN;
        cmd_o.fin_we = out_free;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output item valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.fin_we) begin
      out_valid_d = 1'b1;
    end else if (hash_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign hash_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/murmur_hash2_32_top.sv]
// murmur_hash2_32_top: streaming 32-bit murmurhash2 with seed register
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  data in  | data_valid_i/data_ready_o  | data_word, byte_count, total_length, flags
//  hash out | hash_valid_o/hash_ready_i  | hash_value
//  config   | psel/penable/pwrite/pready | seed at byte address 0
//
// a word item is mixed by three dependent multiplies through one shared 32x32 multiplier
// a last item: word mix, tail multiply or neither, then final multiply and output step
// the hash is registered; the next item is taken while it waits to be collected
// a finished hash stalls in the output step only while the previous one is still held
// reset is asynchronous, active low; the seed resets to 0xEE6B27EB, the hash accumulator to zero
`default_nettype none

module murmur_hash2_32_top
  import mh2_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // data items
  input  wire logic        data_valid_i,
  output logic             data_ready_o,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic [31:0] total_length_i,
  input  wire logic        first_item_i,
  input  wire logic        last_item_i,
  // hash items
  output logic             hash_valid_o,
  input  wire logic        hash_ready_i,
  output logic      [31:0] hash_value_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [31:0] seed_q;
  logic        seed_we;
  mh2_cmd_t    cmd;

  // seed register write
  assign pready  = 1'b1;
  assign seed_we = psel && penable && pwrite && pready && (paddr[2] == RegSeed);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else if (seed_we) begin
      seed_q <= pwdata;
    end
  end

  // register readback
  assign prdata = (paddr[2] == RegSeed) ? seed_q : 32'h0;

  mh2_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_valid_i (data_valid_i),
    .data_ready_o (data_ready_o),
    .byte_count_i (byte_count_i),
    .last_item_i  (last_item_i),
    .hash_valid_o (hash_valid_o),
    .hash_ready_i (hash_ready_i),
    .cmd_o        (cmd)
  );

  mh2_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .seed_i         (seed_q),
    .data_word_i    (data_word_i),
    .byte_count_i   (byte_count_i),
    .total_length_i (total_length_i),
    .first_item_i   (first_item_i),
    .hash_value_o   (hash_value_o)
  );

endmodule

`default_nettype wire

[rtl/mh2_chk.sv]
// mh2_chk: port-level checks on the hash block, bound to the top level
`default_nettype none

module mh2_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        data_valid_i,
  input wire logic        data_ready_o,
  input wire logic        last_item_i,
  input wire logic        hash_valid_o,
  input wire logic        hash_ready_i,
  input wire logic [31:0] hash_value_o
);

  logic in_acc;

  assign in_acc = data_valid_i && data_ready_o;

  // a held hash item keeps its value
  a_hash_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_valid_o && !hash_ready_i |=> hash_valid_o && $stable(hash_value_o))
    else $error("hash item changed while stalled");

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !data_ready_o)
    else $error("input ready right after an accepted item");

  // a new hash comes out of a busy cycle
  a_hash_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hash_valid_o) |-> $past(!data_ready_o))
    else $error("hash appeared while input side was idle");

  // an item that is not last yields no hash
  a_no_hash_mid_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !last_item_i |-> ##3 !$rose(hash_valid_o))
    else $error("hash produced for an item that is not last");

endmodule

bind murmur_hash2_32_top mh2_chk u_mh2_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .data_valid_i (data_valid_i),
  .data_ready_o (data_ready_o),
  .last_item_i  (last_item_i),
  .hash_valid_o (hash_valid_o),
  .hash_ready_i (hash_ready_i),
  .hash_value_o (hash_value_o)
);

`default_nettype wire

[sim/murmur_hash2_32_checker.sv]
// murmur_hash2_32_checker: predicts each hash of the murmurhash2 block and checks the hash items
`timescale 1ns / 1ps

module murmur_hash2_32_checker
  import mh2_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // data channel
  input  logic        data_valid_i,
  input  logic        data_ready_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic [31:0] total_length_i,
  input  logic        first_item_i,
  input  logic        last_item_i,
  // hash channel
  input  logic        hash_valid_i,
  input  logic        hash_ready_i,
  input  logic [31:0] hash_value_i,
  // configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  // status towards the testbench top
  output int unsigned pending_o,
  output int unsigned errors_o,
  output int unsigned hashes_o
);

  localparam logic [2:0] SeedAddr = {RegSeed, 2'b00};

  logic [31:0] seed_q;
  logic [31:0] running_hash;
  logic [31:0] expected_hashes[$];
  logic [31:0] want;
  int unsigned errors;
  int unsigned hashes;

  // one full word mixed into the running hash
  function automatic logic [31:0] mix_word_in(logic [31:0] h, logic [31:0] k);
    logic [31:0] km;
    logic [31:0] hm;
    km = k * MixMul;
    km = km ^ (km >> MixShift);
    km = km * MixMul;
    hm = h * MixMul;
    return hm ^ km;
  endfunction

  // closing avalanche
  function automatic logic [31:0] avalanche_of(logic [31:0] h);
    logic [31:0] x;
    x = h ^ (h >> FinShiftA);
    x = x * MixMul;
    x = x ^ (x >> FinShiftB);
    return x;
  endfunction

  // fold one accepted item into the running hash, queue the hash on a last item
  task automatic absorb_item();
    logic [31:0] h;
    logic [31:0] mask;
    logic [2:0]  n;
    h = running_hash;
    n = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
    if (first_item_i) begin
      h = seed_q ^ total_length_i;
    end
    if (!last_item_i || n == 3'd4) begin
      h = mix_word_in(h, data_word_i);
    end else if (n != 3'd0) begin
      mask = 32'hFFFF_FFFF >> (32 - 8 * int'(n));
      h = h ^ (data_word_i & mask);
      h = h * MixMul;
    end
    if (last_item_i) begin
      h = avalanche_of(h);
      expected_hashes.push_back(h);
    end
    running_hash = h;
  endtask

  // watch all three ports on every edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q = SeedReset;
      running_hash = '0;
      expected_hashes.delete();
      errors = 0;
      hashes = 0;
      pending_o <= 0;
      errors_o <= 0;
      hashes_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == SeedAddr) begin
        seed_q = pwdata_i;
      end
      if (data_valid_i && data_ready_i) begin
        absorb_item();
      end
      if (hash_valid_i && hash_ready_i) begin
        if (expected_hashes.size() == 0) begin
          $display("%0t: hash item %08h with none expected", $time, hash_value_i);
          errors++;
        end else begin
          want = expected_hashes.pop_front();
          hashes++;
          if (hash_value_i !== want) begin
            $display("%0t: hash mismatch, expected %08h, actual %08h",
                     $time, want, hash_value_i);
            errors++;
          end
        end
      end
      pending_o <= expected_hashes.size();
      errors_o <= errors;
      hashes_o <= hashes;
    end
  end

endmodule

[sim/tb_murmur_hash2_32_top.sv]
// tb_murmur_hash2_32_top: stimulus, seed writes and verdict for the murmurhash2 block
`timescale 1ns / 1ps

module tb_murmur_hash2_32_top;
  import mh2_pkg::*;

  localparam int unsigned ItemTarget = 1850;
  localparam int unsigned MaxGap     = 16;
  localparam int unsigned SettleCyc  = 8;
  localparam logic [2:0]  SeedAddr   = {RegSeed, 2'b00};

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        data_valid_i   = 1'b0;
  logic [31:0] data_word_i    = '0;
  logic [2:0]  byte_count_i   = '0;
  logic [31:0] total_length_i = '0;
  logic        first_item_i   = 1'b0;
  logic        last_item_i    = 1'b0;
  logic        hash_ready_i   = 1'b0;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;

  logic        data_ready_o;
  logic        hash_valid_o;
  logic [31:0] hash_value_o;
  logic [31:0] prdata;
  logic        pready;

  int unsigned pending;
  int unsigned errors;
  int unsigned hashes;

  int unsigned items_sent;
  int unsigned messages_sent;
  int unsigned seeds_written;
  bit          no_idle;

  murmur_hash2_32_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_valid_i   (data_valid_i),
    .data_ready_o   (data_ready_o),
    .data_word_i    (data_word_i),
    .byte_count_i   (byte_count_i),
    .total_length_i (total_length_i),
    .first_item_i   (first_item_i),
    .last_item_i    (last_item_i),
    .hash_valid_o   (hash_valid_o),
    .hash_ready_i   (hash_ready_i),
    .hash_value_o   (hash_value_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  murmur_hash2_32_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_valid_i   (data_valid_i),
    .data_ready_i   (data_ready_o),
    .data_word_i    (data_word_i),
    .byte_count_i   (byte_count_i),
    .total_length_i (total_length_i),
    .first_item_i   (first_item_i),
    .last_item_i    (last_item_i),
    .hash_valid_i   (hash_valid_o),
    .hash_ready_i   (hash_ready_i),
    .hash_value_i   (hash_value_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .pending_o      (pending),
    .errors_o       (errors),
    .hashes_o       (hashes)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("tb_murmur_hash2_32_top failed");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // hash side: random stall before each item
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        hash_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      hash_ready_i <= 1'b1;
      do @(posedge clk_i); while (!hash_valid_o);
    end
  end

  // one data item, valid held until taken
  task automatic send_item(input logic [31:0] word, input logic [2:0] count,
                           input logic [31:0] total, input logic is_first,
                           input logic is_last);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      data_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    data_valid_i   <= 1'b1;
    data_word_i    <= word;
    byte_count_i   <= count;
    total_length_i <= total;
    first_item_i   <= is_first;
    last_item_i    <= is_last;
    do @(posedge clk_i); while (!data_ready_o);
    items_sent++;
  endtask

  // random message, mostly well formed
  task automatic send_message();
    int unsigned len;
    int unsigned nwords;
    int unsigned tail;
    int unsigned body;
    int unsigned i;
    logic [31:0] total;
    logic [2:0]  cnt;
    bit          headless;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 40);
    nwords = len / 4;
    tail = len % 4;
    total = ($urandom_range(0, 7) == 0) ? $urandom() : len;
    headless = ($urandom_range(0, 15) == 0);
    // word-aligned messages end either on their final word or on an empty item
    body = (tail == 0 && nwords > 0 && $urandom_range(0, 1) == 1) ? nwords - 1 : nwords;
    for (i = 0; i < body; i++) begin
      cnt = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      send_item($urandom(), cnt, total, (i == 0) && !headless, 1'b0);
    end
    if (body < nwords) begin
      cnt = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(5, 7)) : 3'd4;
    end else begin
      cnt = 3'(tail);
    end
    send_item($urandom(), cnt, total, (body == 0) && !headless, 1'b1);
    messages_sent++;
  endtask

  // loose items with any flags and counts
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      send_item($urandom(), 3'($urandom_range(0, 7)), $urandom(),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // stop sending and let every hash come out
  task automatic drain();
    data_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // apb write of the seed register, setup then access
  task automatic write_seed(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SeedAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seeds_written++;
  endtask

  // main sequence
  initial begin
    logic [31:0] seed_plan[4];
    int unsigned directed;
    int unsigned p;
    items_sent = 0;
    messages_sent = 0;
    seeds_written = 0;
    no_idle = 1'b0;
    seed_plan[0] = 32'h0000_0000;
    seed_plan[1] = 32'hFFFF_FFFF;
    seed_plan[2] = $urandom();
    seed_plan[3] = $urandom();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // continuation straight after reset: accumulator still zero
    send_item(32'hA5A5_00FF, 3'd2, 32'd0, 1'b0, 1'b1);
    // single-item messages, empty and full
    send_item(32'h0000_0000, 3'd0, 32'd0, 1'b1, 1'b1);
    send_item(32'hFFFF_FFFF, 3'd4, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // tails with junk above the valid bytes
    send_item(32'hDEAD_BE01, 3'd1, 32'd1, 1'b1, 1'b1);
    send_item(32'hCAFE_F00D, 3'd2, 32'd2, 1'b1, 1'b1);
    send_item(32'h8765_4321, 3'd3, 32'd3, 1'b1, 1'b1);
    // oversized byte counts act as a full word
    send_item(32'h0123_4567, 3'd5, 32'd4, 1'b1, 1'b1);
    send_item(32'h89AB_CDEF, 3'd6, 32'd4, 1'b1, 1'b1);
    send_item(32'h7FFF_FFFF, 3'd7, 32'd4, 1'b1, 1'b1);
    // four-item message, short counts on items that are not last ignored
    send_item(32'h6C6C_6548, 3'd1, 32'd13, 1'b1, 1'b0);
    send_item(32'h6F77_206F, 3'd0, 32'd13, 1'b0, 1'b0);
    send_item(32'h2164_6C72, 3'd7, 32'd13, 1'b0, 1'b0);
    send_item(32'h0000_0021, 3'd1, 32'd13, 1'b0, 1'b1);
    // continuing from the previous finished hash
    send_item(32'h1357_9BDF, 3'd4, 32'h0000_0000, 1'b0, 1'b0);
    send_item(32'h2468_ACE0, 3'd3, 32'h0000_0000, 1'b0, 1'b1);
    // length far from the bytes delivered, empty last item
    send_item(32'h0000_0000, 3'd4, 32'h8000_0000, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 3'd0, 32'h0000_0000, 1'b0, 1'b1);
    directed = items_sent;

    // random traffic under several seeds, extremes first
    for (p = 0; p < 4; p++) begin
      drain();
      write_seed(seed_plan[p]);
      while (items_sent < directed + (p + 1) * ItemTarget / 4) begin
        if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_message();
      end
    end
    drain();

    $display("run covered %0d items in %0d random messages plus noise, %0d seed writes",
             items_sent, messages_sent, seeds_written);
    $display("%0d hashes compared, %0d errors, %0d hashes never delivered",
             hashes, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("tb_murmur_hash2_32_top passed");
    end else begin
      $display("tb_murmur_hash2_32_top failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mh2_pkg.sv
rtl/mh2_dp.sv
rtl/mh2_ctrl.sv
rtl/murmur_hash2_32_top.sv
rtl/mh2_chk.sv
sim/murmur_hash2_32_checker.sv
sim/tb_murmur_hash2_32_top.sv
